// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL. Both sample on clk and are off in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// When ante holds in a cycle, cons must hold in the same cycle.
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// cond must never be true.
`define ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("forbidden condition seen");

`endif

// ----- rtl/pbm_pkg.sv -----
package pbm_pkg;

	// number of colour lanes (red, green, blue)
	localparam int NLANE = 3;

	// configuration register indexes
	localparam logic [2:0] CFG_BLEND_MODE  = 3'd0;
	localparam logic [2:0] CFG_RED_SLOT    = 3'd1;
	localparam logic [2:0] CFG_GREEN_SLOT  = 3'd2;
	localparam logic [2:0] CFG_BLUE_SLOT   = 3'd3;
	localparam logic [2:0] CFG_ALPHA_SLOT  = 3'd4;

	typedef enum logic [3:0] {
		MODE_NORMAL     = 4'd0,
		MODE_MULTIPLY   = 4'd1,
		MODE_SCREEN     = 4'd2,
		MODE_DARKEN     = 4'd3,
		MODE_LIGHTEN    = 4'd4,
		MODE_SOFTLIGHT  = 4'd5,
		MODE_HARDLIGHT  = 4'd6,
		MODE_COLORDODGE = 4'd7,
		MODE_COLORBURN  = 4'd8,
		MODE_OVERLAY    = 4'd9,
		MODE_EXCLUSION  = 4'd10,
		MODE_DIFFERENCE = 4'd11
	} blend_mode_t;

	// how a lane's result is finished after the divide / square-root stages
	typedef enum logic [1:0] {
		FIN_DIRECT = 2'd0,
		FIN_SQRT   = 2'd1,
		FIN_DODGE  = 2'd2,
		FIN_BURN   = 2'd3
	} fin_kind_t;

	typedef struct packed {
		logic [7:0] top_byte0;
		logic [7:0] top_byte1;
		logic [7:0] top_byte2;
		logic [7:0] top_byte3;
		logic [7:0] back_byte0;
		logic [7:0] back_byte1;
		logic [7:0] back_byte2;
		logic [7:0] back_byte3;
	} pixel_in_t;

	typedef struct packed {
		logic [7:0] out_byte0;
		logic [7:0] out_byte1;
		logic [7:0] out_byte2;
		logic [7:0] out_byte3;
	} pixel_out_t;

endpackage

// ----- rtl/pixel_blend_modes_unit.sv -----
// Channel    Signals                               Direction  Handshake
// command    start, busy, pixel                    in         start & !busy
// result     done, result                          out        done strobe, one cycle
// config     cfg_valid, cfg_ready, cfg_index,      in         cfg_valid & cfg_ready
//            cfg_data
//
// One pixel pair is taken every cycle; busy stays low.
// A result is registered through stages 1 to 9; the divider and square-root
// section in stage 6 gives one quotient / root bit per stage over FRAC_BITS+1
// stages.
// arst_n clears the valid bits and loads the register defaults.
// The result side cannot stall, so the pipeline never holds.
`include "assert_macros.svh"

module pixel_blend_modes_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  pbm_pkg::pixel_in_t   pixel,
	output logic                 done,
	output pbm_pkg::pixel_out_t  result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [3:0]           cfg_data
);

	localparam int F  = FRAC_BITS;
	localparam int N  = F + 1;       // iteration stages
	localparam int FW = F + 1;       // 0..ONE
	localparam int BW = F + 2;       // 0..2*ONE
	localparam int RW = F + 6;       // signed blend results
	localparam int MW = 2 * F + 2;   // square-root remainder
	localparam int SW = MW + 1;      // square-root trial value
	localparam int NL = pbm_pkg::NLANE;

	localparam logic [FW-1:0]        ONE_F  = {1'b1, {F{1'b0}}};
	localparam logic [FW-1:0]        HALF_F = FW'(1) << (F - 1);
	localparam logic [BW-1:0]        ONE_B  = BW'(ONE_F);
	localparam logic [BW-1:0]        HALF_B = BW'(HALF_F);
	localparam logic signed [RW-1:0] ONE_R  = $signed(RW'(ONE_F));

	typedef struct packed {
		logic [BW-1:0]          rem_d;
		logic [BW-1:0]          dvs;
		logic [N-1:0]           quo;
		logic [MW-1:0]          rem_s;
		logic [N-1:0]           root;
		logic signed [RW-1:0]   r_pre;
		logic [BW-1:0]          aux;
		pbm_pkg::fin_kind_t     kind;
	} lane_it_t;

	// x*y/ONE, truncated toward zero
	function automatic logic signed [RW-1:0] fmul(input logic signed [RW-1:0] x,
			input logic signed [RW-1:0] y);
		logic signed [2*RW-1:0] p;
		p = x * y;
		if (p < 0)
			p = p + $signed({{(2*RW-F){1'b0}}, {F{1'b1}}});
		fmul = RW'(p >>> F);
	endfunction

	function automatic logic signed [RW-1:0] sx(input logic [BW-1:0] v);
		sx = $signed(RW'(v));
	endfunction

	// clamp and scale a fixed-point value to a byte
	function automatic logic [7:0] to_byte(input logic signed [RW-1:0] r);
		logic [F-1:0]   v;
		logic [F+7:0]   t;
		v = F'(r);
		t = {v, 8'b0} - (F+8)'(v);
		if (r <= 0)
			to_byte = 8'd0;
		else if (r >= ONE_R)
			to_byte = 8'd255;
		else
			to_byte = t[F+7:F];
	endfunction

	// byte -> ceil(v*ONE/255), built at elaboration
	logic [FW-1:0] fix_tbl [256];
	for (genvar g = 0; g < 256; g++) begin : g_fix
		localparam logic [FW-1:0] FIXV = FW'(((64'(g) << F) + 64'd254) / 64'd255);
		assign fix_tbl[g] = FIXV;
	end

	// configuration registers
	pbm_pkg::blend_mode_t mode_q;
	logic [1:0]           slot_q [4];   // red, green, blue, alpha

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= pbm_pkg::MODE_NORMAL;
			slot_q[0] <= 2'd0;
			slot_q[1] <= 2'd1;
			slot_q[2] <= 2'd2;
			slot_q[3] <= 2'd3;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pbm_pkg::CFG_BLEND_MODE: mode_q <= pbm_pkg::blend_mode_t'(cfg_data);
				pbm_pkg::CFG_RED_SLOT:   slot_q[0] <= cfg_data[1:0];
				pbm_pkg::CFG_GREEN_SLOT: slot_q[1] <= cfg_data[1:0];
				pbm_pkg::CFG_BLUE_SLOT:  slot_q[2] <= cfg_data[1:0];
				pbm_pkg::CFG_ALPHA_SLOT: slot_q[3] <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// valid bits
	logic          vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [N:0]    itr_vld_s6;
	logic          vld_s7, vld_s8, vld_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			vld_s3     <= 1'b0;
			vld_s4     <= 1'b0;
			vld_s5     <= 1'b0;
			itr_vld_s6 <= '0;
			vld_s7     <= 1'b0;
			vld_s8     <= 1'b0;
			vld_s9     <= 1'b0;
		end else begin
			vld_s1     <= start && !busy;
			vld_s2     <= vld_s1;
			vld_s3     <= vld_s2;
			vld_s4     <= vld_s3;
			vld_s5     <= vld_s4;
			itr_vld_s6 <= {itr_vld_s6[N-1:0], vld_s5};
			vld_s7     <= itr_vld_s6[N];
			vld_s8     <= vld_s7;
			vld_s9     <= vld_s8;
		end
	end

	// stage 1: pick channel bytes, convert to fixed point
	logic [7:0]    top_b [4];
	logic [7:0]    back_b [4];
	logic [FW-1:0] ca_s1 [NL];
	logic [FW-1:0] cb_s1 [NL];
	logic [FW-1:0] qa_s1, qb_s1;

	assign top_b[0]  = pixel.top_byte0;
	assign top_b[1]  = pixel.top_byte1;
	assign top_b[2]  = pixel.top_byte2;
	assign top_b[3]  = pixel.top_byte3;
	assign back_b[0] = pixel.back_byte0;
	assign back_b[1] = pixel.back_byte1;
	assign back_b[2] = pixel.back_byte2;
	assign back_b[3] = pixel.back_byte3;

	always_ff @(posedge clk) begin
		for (int l = 0; l < NL; l++) begin
			ca_s1[l] <= fix_tbl[top_b[slot_q[l]]];
			cb_s1[l] <= fix_tbl[back_b[slot_q[l]]];
		end
		qa_s1 <= fix_tbl[top_b[slot_q[3]]];
		qb_s1 <= fix_tbl[back_b[slot_q[3]]];
	end

	// stage 2: first products, alpha union
	logic [FW-1:0] pa_s2 [NL];
	logic [FW-1:0] pb_s2 [NL];
	logic [FW-1:0] pc_s2 [NL];
	logic [FW-1:0] ca_s2 [NL];
	logic [FW-1:0] cb_s2 [NL];
	logic [FW-1:0] qr_s2;
	logic [FW-1:0] pa_c [NL];
	logic [FW-1:0] pb_c [NL];
	logic [FW-1:0] pc_c [NL];
	logic [FW-1:0] qr_c;

	always_comb begin
		logic [FW-1:0]   ia, ib;
		logic [2*FW-1:0] pr;
		ia = ONE_F - qa_s1;
		ib = ONE_F - qb_s1;
		for (int l = 0; l < NL; l++) begin
			pr = ia * cb_s1[l];
			pa_c[l] = pr[2*F:F];
			pr = ib * ca_s1[l];
			pb_c[l] = pr[2*F:F];
			pr = ca_s1[l] * cb_s1[l];
			pc_c[l] = pr[2*F:F];
		end
		pr = ia * ib;
		qr_c = ONE_F - pr[2*F:F];
	end

	always_ff @(posedge clk) begin
		pa_s2 <= pa_c;
		pb_s2 <= pb_c;
		pc_s2 <= pc_c;
		ca_s2 <= ca_s1;
		cb_s2 <= cb_s1;
		qr_s2 <= qr_c;
	end

	// stage 3: backdrop / source mixes and additive modes
	logic [BW-1:0]        bcb_s3 [NL];
	logic [BW-1:0]        bca_s3 [NL];
	logic signed [RW-1:0] rmul_s3 [NL];
	logic signed [RW-1:0] rscr_s3 [NL];
	logic                 cblo_s3 [NL];
	logic [FW-1:0]        qr_s3;

	always_ff @(posedge clk) begin
		for (int l = 0; l < NL; l++) begin
			bcb_s3[l]  <= BW'(pa_s2[l]) + BW'(ca_s2[l]);
			bca_s3[l]  <= BW'(pb_s2[l]) + BW'(cb_s2[l]);
			rmul_s3[l] <= sx(BW'(pa_s2[l])) + sx(BW'(pb_s2[l])) + sx(BW'(pc_s2[l]));
			rscr_s3[l] <= sx(BW'(ca_s2[l])) + sx(BW'(cb_s2[l])) - sx(BW'(pc_s2[l]));
			cblo_s3[l] <= cb_s2[l] < HALF_F;
		end
		qr_s3 <= qr_s2;
	end

	// stage 4: second products, simple modes
	logic signed [RW-1:0] m1_s4 [NL];
	logic signed [RW-1:0] m2_s4 [NL];
	logic signed [RW-1:0] m3_s4 [NL];
	logic signed [RW-1:0] m4_s4 [NL];
	logic signed [RW-1:0] rsim_s4 [NL];
	logic [BW-1:0]        bcb_s4 [NL];
	logic [BW-1:0]        bca_s4 [NL];
	logic                 cblo_s4 [NL];
	logic [FW-1:0]        qr_s4;
	logic signed [RW-1:0] m1_c [NL];
	logic signed [RW-1:0] m2_c [NL];
	logic signed [RW-1:0] m3_c [NL];
	logic signed [RW-1:0] m4_c [NL];
	logic signed [RW-1:0] rsim_c [NL];

	always_comb begin
		logic signed [RW-1:0] a, b;
		for (int l = 0; l < NL; l++) begin
			a = sx(bca_s3[l]);
			b = sx(bcb_s3[l]);
			m1_c[l] = fmul(a + a, b);
			m2_c[l] = fmul(a, a);
			m3_c[l] = fmul((ONE_R - a) + (ONE_R - a), ONE_R - b);
			m4_c[l] = fmul(a + a, ONE_R - b);
			case (mode_q)
				pbm_pkg::MODE_MULTIPLY:   rsim_c[l] = rmul_s3[l];
				pbm_pkg::MODE_SCREEN:     rsim_c[l] = rscr_s3[l];
				pbm_pkg::MODE_DARKEN:     rsim_c[l] = (b < a) ? b : a;
				pbm_pkg::MODE_LIGHTEN:    rsim_c[l] = (b > a) ? b : a;
				pbm_pkg::MODE_DIFFERENCE: rsim_c[l] = (a >= b) ? a - b : b - a;
				default:                  rsim_c[l] = b;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		m1_s4   <= m1_c;
		m2_s4   <= m2_c;
		m3_s4   <= m3_c;
		m4_s4   <= m4_c;
		rsim_s4 <= rsim_c;
		bcb_s4  <= bcb_s3;
		bca_s4  <= bca_s3;
		cblo_s4 <= cblo_s3;
		qr_s4   <= qr_s3;
	end

	// stage 5: soft-light square term
	logic signed [RW-1:0] m1_s5 [NL];
	logic signed [RW-1:0] m3_s5 [NL];
	logic signed [RW-1:0] m4_s5 [NL];
	logic signed [RW-1:0] m5_s5 [NL];
	logic signed [RW-1:0] rsim_s5 [NL];
	logic [BW-1:0]        bcb_s5 [NL];
	logic [BW-1:0]        bca_s5 [NL];
	logic                 cblo_s5 [NL];
	logic [FW-1:0]        qr_s5;

	always_ff @(posedge clk) begin
		for (int l = 0; l < NL; l++)
			m5_s5[l] <= fmul(m2_s4[l], ONE_R - sx(bcb_s4[l]) - sx(bcb_s4[l]));
		m1_s5   <= m1_s4;
		m3_s5   <= m3_s4;
		m4_s5   <= m4_s4;
		rsim_s5 <= rsim_s4;
		bcb_s5  <= bcb_s4;
		bca_s5  <= bca_s4;
		cblo_s5 <= cblo_s4;
		qr_s5   <= qr_s4;
	end

	// stage 6: mode select and divider / square-root setup
	lane_it_t      itr_s6 [N+1][NL];
	logic [FW-1:0] qr_it_s6 [N+1];
	lane_it_t      itr_init [NL];

	always_comb begin
		logic signed [RW-1:0] a, b;
		for (int l = 0; l < NL; l++) begin
			a = sx(bca_s5[l]);
			b = sx(bcb_s5[l]);
			itr_init[l].kind  = pbm_pkg::FIN_DIRECT;
			itr_init[l].r_pre = rsim_s5[l];
			itr_init[l].rem_d = bca_s5[l];
			itr_init[l].dvs   = ONE_B;
			itr_init[l].quo   = '0;
			itr_init[l].rem_s = {bca_s5[l], {F{1'b0}}};
			itr_init[l].root  = '0;
			itr_init[l].aux   = BW'({bcb_s5[l], 1'b0} - {1'b0, ONE_B});
			case (mode_q)
				pbm_pkg::MODE_SOFTLIGHT: begin
					if (bcb_s5[l] < HALF_B)
						itr_init[l].r_pre = m1_s5[l] + m5_s5[l];
					else begin
						itr_init[l].kind  = pbm_pkg::FIN_SQRT;
						itr_init[l].r_pre = m4_s5[l];
					end
				end
				pbm_pkg::MODE_HARDLIGHT: begin
					itr_init[l].r_pre = cblo_s5[l] ? m1_s5[l] : ONE_R - m3_s5[l];
				end
				pbm_pkg::MODE_OVERLAY: begin
					itr_init[l].r_pre = (bca_s5[l] < HALF_B) ? m1_s5[l] : ONE_R - m3_s5[l];
				end
				pbm_pkg::MODE_EXCLUSION: begin
					itr_init[l].r_pre = a + b - m1_s5[l];
				end
				pbm_pkg::MODE_COLORDODGE: begin
					itr_init[l].rem_d = bca_s5[l];
					itr_init[l].dvs   = ONE_B - bcb_s5[l];
					if (bcb_s5[l] == ONE_B)
						itr_init[l].r_pre = ONE_R;
					else if (bcb_s5[l] > ONE_B)
						itr_init[l].r_pre = '0;
					else if (bca_s5[l] >= ONE_B - bcb_s5[l])
						itr_init[l].r_pre = ONE_R;
					else
						itr_init[l].kind = pbm_pkg::FIN_DODGE;
				end
				pbm_pkg::MODE_COLORBURN: begin
					itr_init[l].rem_d = ONE_B - bca_s5[l];
					itr_init[l].dvs   = bcb_s5[l];
					if (bcb_s5[l] == '0)
						itr_init[l].r_pre = '0;
					else if (bca_s5[l] > ONE_B)
						itr_init[l].r_pre = ONE_R;
					else if (ONE_B - bca_s5[l] >= bcb_s5[l])
						itr_init[l].r_pre = '0;
					else
						itr_init[l].kind = pbm_pkg::FIN_BURN;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		itr_s6[0]   <= itr_init;
		qr_it_s6[0] <= qr_s5;
	end

	// divide and square-root stages, one bit each
	for (genvar k = 0; k < N; k++) begin : g_itr
		localparam int I = N - 1 - k;
		lane_it_t itr_nxt [NL];

		always_comb begin
			logic [BW:0]   t;
			logic [SW-1:0] trial;
			for (int l = 0; l < NL; l++) begin
				itr_nxt[l] = itr_s6[k][l];
				// restoring divide step
				t = {itr_s6[k][l].rem_d, 1'b0};
				if (t >= {1'b0, itr_s6[k][l].dvs}) begin
					itr_nxt[l].rem_d = BW'(t - {1'b0, itr_s6[k][l].dvs});
					itr_nxt[l].quo   = {itr_s6[k][l].quo[N-2:0], 1'b1};
				end else begin
					itr_nxt[l].rem_d = BW'(t);
					itr_nxt[l].quo   = {itr_s6[k][l].quo[N-2:0], 1'b0};
				end
				// root bit I
				trial = (SW'(itr_s6[k][l].root) << (I + 1)) + (SW'(1) << (2 * I));
				if (SW'(itr_s6[k][l].rem_s) >= trial) begin
					itr_nxt[l].rem_s   = MW'(SW'(itr_s6[k][l].rem_s) - trial);
					itr_nxt[l].root[I] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk) begin
			itr_s6[k+1]   <= itr_nxt;
			qr_it_s6[k+1] <= qr_it_s6[k];
		end
	end

	// stage 7: soft-light root product
	logic signed [RW-1:0] m6_s7 [NL];
	logic signed [RW-1:0] rpre_s7 [NL];
	logic [F-1:0]         q_s7 [NL];
	pbm_pkg::fin_kind_t   kind_s7 [NL];
	logic [FW-1:0]        qr_s7;

	always_ff @(posedge clk) begin
		for (int l = 0; l < NL; l++) begin
			m6_s7[l]   <= fmul(sx(BW'(itr_s6[N][l].root)), sx(itr_s6[N][l].aux));
			rpre_s7[l] <= itr_s6[N][l].r_pre;
			q_s7[l]    <= itr_s6[N][l].quo[N-1:1];
			kind_s7[l] <= itr_s6[N][l].kind;
		end
		qr_s7 <= qr_it_s6[N];
	end

	// stage 8: final blend value
	logic signed [RW-1:0] r_s8 [NL];
	logic [FW-1:0]        qr_s8;

	always_ff @(posedge clk) begin
		for (int l = 0; l < NL; l++) begin
			case (kind_s7[l])
				pbm_pkg::FIN_SQRT:  r_s8[l] <= m6_s7[l] + rpre_s7[l];
				pbm_pkg::FIN_DODGE: r_s8[l] <= sx(BW'(q_s7[l]));
				pbm_pkg::FIN_BURN:  r_s8[l] <= ONE_R - sx(BW'(q_s7[l]));
				default:            r_s8[l] <= rpre_s7[l];
			endcase
		end
		qr_s8 <= qr_s7;
	end

	// stage 9: bytes into their slots; alpha wins a shared slot
	logic [7:0]     res_c [4];
	logic [FW+7:0]  at_c;

	always_comb begin
		for (int p = 0; p < 4; p++)
			res_c[p] = 8'd0;
		for (int l = 0; l < NL; l++)
			res_c[slot_q[l]] = to_byte(r_s8[l]);
		at_c = {qr_s8, 8'b0} - (FW+8)'(qr_s8);
		res_c[slot_q[3]] = at_c[F+7:F];
	end

	pbm_pkg::pixel_out_t result_s9;

	always_ff @(posedge clk) begin
		result_s9.out_byte0 <= res_c[0];
		result_s9.out_byte1 <= res_c[1];
		result_s9.out_byte2 <= res_c[2];
		result_s9.out_byte3 <= res_c[3];
	end

	assign done   = vld_s9;
	assign result = result_s9;

	// for dodge and burn, the divider of lane 0 only ever sees a numerator below its divisor
	`ASSERT_IMPL(a_div_in_range, itr_vld_s6[0] && (itr_s6[0][0].kind == pbm_pkg::FIN_DODGE || itr_s6[0][0].kind == pbm_pkg::FIN_BURN), itr_s6[0][0].rem_d < itr_s6[0][0].dvs)
	// root path is used by soft light alone
	`ASSERT_NEVER(a_sqrt_softlight, itr_vld_s6[N] && itr_s6[N][0].kind == pbm_pkg::FIN_SQRT && mode_q != pbm_pkg::MODE_SOFTLIGHT)

endmodule

// ----- tb/pixel_blend_modes_unit_tb.sv -----
`timescale 1ns / 1ps

// Keeps the blend settings seen by the block and the queue of expected pixels.
class blend_scoreboard;
	localparam int FRAC = 16;
	localparam longint ONE = longint'(1) << FRAC;
	localparam longint HALF = ONE / 2;

	logic [3:0] mode;
	logic [1:0] slot[4];	// red, green, blue, alpha
	pbm_pkg::pixel_out_t expected_pixels[$];
	int errors;
	int checked;

	function new();
		mode = pbm_pkg::MODE_NORMAL;
		slot = '{2'd0, 2'd1, 2'd2, 2'd3};
		errors = 0;
		checked = 0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [3:0] data);
		case (idx)
			pbm_pkg::CFG_BLEND_MODE: mode = data;
			pbm_pkg::CFG_RED_SLOT: slot[0] = data[1:0];
			pbm_pkg::CFG_GREEN_SLOT: slot[1] = data[1:0];
			pbm_pkg::CFG_BLUE_SLOT: slot[2] = data[1:0];
			pbm_pkg::CFG_ALPHA_SLOT: slot[3] = data[1:0];
			default: ;
		endcase
	endfunction

	// byte to fixed point, rounding up so 255 lands on ONE
	static function longint fix_of(logic [7:0] v);
		return (longint'(v) * ONE + 254) / 255;
	endfunction

	static function longint fmul(longint x, longint y);
		return (x * y) / ONE;
	endfunction

	static function longint fdiv(longint x, longint y);
		return (x * ONE) / y;
	endfunction

	// bitwise integer root of x scaled up by ONE
	static function longint froot(longint x);
		longint unsigned n;
		longint unsigned r;
		longint unsigned b;
		n = longint'(x) << FRAC;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	static function logic [7:0] byte_of(longint r);
		longint t;
		if (r <= 0) return 8'd0;
		if (r >= ONE) return 8'd255;
		t = (r * 255) >>> FRAC;
		return t[7:0];
	endfunction

	function logic [7:0] blend_lane(longint ca, longint cb, longint qa, longint qb);
		longint bcb;
		longint bca;
		longint r;
		bcb = fmul(ONE - qa, cb) + ca;
		bca = fmul(ONE - qb, ca) + cb;
		case (mode)
			pbm_pkg::MODE_MULTIPLY:
				r = fmul(ONE - qa, cb) + fmul(ONE - qb, ca) + fmul(ca, cb);
			pbm_pkg::MODE_SCREEN: r = cb + ca - fmul(ca, cb);
			pbm_pkg::MODE_DARKEN: r = (bcb < bca) ? bcb : bca;
			pbm_pkg::MODE_LIGHTEN: r = (bcb > bca) ? bcb : bca;
			pbm_pkg::MODE_SOFTLIGHT: begin
				if (bcb < HALF)
					r = fmul(2 * bca, bcb) + fmul(fmul(bca, bca), ONE - 2 * bcb);
				else
					r = fmul(froot(bca), 2 * bcb - ONE) + fmul(2 * bca, ONE - bcb);
			end
			pbm_pkg::MODE_HARDLIGHT: begin
				if (cb < HALF) r = fmul(2 * bca, bcb);
				else r = ONE - fmul(2 * (ONE - bca), ONE - bcb);
			end
			pbm_pkg::MODE_COLORDODGE: begin
				if (bcb == ONE) r = ONE;
				else begin
					r = fdiv(bca, ONE - bcb);
					if (r > ONE) r = ONE;
				end
			end
			pbm_pkg::MODE_COLORBURN: begin
				if (bcb == 0) r = 0;
				else begin
					r = ONE - fdiv(ONE - bca, bcb);
					if (r < 0) r = 0;
				end
			end
			pbm_pkg::MODE_OVERLAY: begin
				if (bca < HALF) r = fmul(2 * bca, bcb);
				else r = ONE - fmul(2 * (ONE - bca), ONE - bcb);
			end
			pbm_pkg::MODE_EXCLUSION: r = bca + bcb - fmul(2 * bca, bcb);
			pbm_pkg::MODE_DIFFERENCE: r = (bca >= bcb) ? bca - bcb : bcb - bca;
			default: r = bcb;	// normal, and the unused codes
		endcase
		return byte_of(r);
	endfunction

	// accepted pixel pair: work out the blended pixel
	function void note_pixel(pbm_pkg::pixel_in_t p);
		logic [7:0] top[4];
		logic [7:0] back[4];
		logic [7:0] res[4];
		longint qa;
		longint qb;
		longint qr;
		longint t;
		pbm_pkg::pixel_out_t o;
		top = '{p.top_byte0, p.top_byte1, p.top_byte2, p.top_byte3};
		back = '{p.back_byte0, p.back_byte1, p.back_byte2, p.back_byte3};
		res = '{8'd0, 8'd0, 8'd0, 8'd0};
		qa = fix_of(top[slot[3]]);
		qb = fix_of(back[slot[3]]);
		// later lanes overwrite earlier ones on a shared slot
		for (int ch = 0; ch < 3; ch++)
			res[slot[ch]] = blend_lane(fix_of(top[slot[ch]]), fix_of(back[slot[ch]]), qa, qb);
		qr = ONE - fmul(ONE - qa, ONE - qb);
		t = (qr * 255) >>> FRAC;
		res[slot[3]] = t[7:0];
		o.out_byte0 = res[0];
		o.out_byte1 = res[1];
		o.out_byte2 = res[2];
		o.out_byte3 = res[3];
		expected_pixels.push_back(o);
	endfunction

	function void check_pixel(pbm_pkg::pixel_out_t got);
		pbm_pkg::pixel_out_t want;
		if (expected_pixels.size() == 0) begin
			$display("%0t: unexpected result %h", $realtime, got);
			errors++;
			return;
		end
		want = expected_pixels.pop_front();
		checked++;
		if (got.out_byte0 !== want.out_byte0)
			$display("%0t: out_byte0 exp %h got %h", $realtime, want.out_byte0, got.out_byte0);
		if (got.out_byte1 !== want.out_byte1)
			$display("%0t: out_byte1 exp %h got %h", $realtime, want.out_byte1, got.out_byte1);
		if (got.out_byte2 !== want.out_byte2)
			$display("%0t: out_byte2 exp %h got %h", $realtime, want.out_byte2, got.out_byte2);
		if (got.out_byte3 !== want.out_byte3)
			$display("%0t: out_byte3 exp %h got %h", $realtime, want.out_byte3, got.out_byte3);
		if (got !== want) errors++;
	endfunction
endclass

module pixel_blend_modes_unit_tb;
	localparam int FRAC_BITS = 16;
	localparam int LATENCY = FRAC_BITS + 10;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	pbm_pkg::pixel_in_t pixel;
	logic done;
	pbm_pkg::pixel_out_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [3:0] cfg_data;

	blend_scoreboard blend_sb;
	bit no_gaps;
	int pixels_sent;
	int phases_run;

	pixel_blend_modes_unit #(.FRAC_BITS(FRAC_BITS)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .pixel(pixel),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("timeout");
		$display("pixel_blend_modes_unit_tb NOT OK");
		$finish;
	end

	// watch accepted beats on every channel
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) blend_sb.write_reg(cfg_index, cfg_data);
			if (start && !busy) blend_sb.note_pixel(pixel);
			if (done) blend_sb.check_pixel(result);
		end
	end

	// writes all five registers back to back
	task automatic set_blend(logic [3:0] mode, logic [1:0] r, logic [1:0] g,
			logic [1:0] b, logic [1:0] a);
		logic [2:0] idx[5];
		logic [3:0] val[5];
		idx = '{pbm_pkg::CFG_BLEND_MODE, pbm_pkg::CFG_RED_SLOT, pbm_pkg::CFG_GREEN_SLOT,
			pbm_pkg::CFG_BLUE_SLOT, pbm_pkg::CFG_ALPHA_SLOT};
		val = '{mode, {2'b0, r}, {2'b0, g}, {2'b0, b}, {2'b0, a}};
		for (int i = 0; i < 5; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		phases_run++;
	endtask

	// wait for the pipeline to empty before touching the registers
	task automatic drain();
		while (blend_sb.expected_pixels.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// a random gap before a quarter of the beats keeps idle near 38%
	task automatic send_pixel(pbm_pkg::pixel_in_t p);
		if (!no_gaps && $urandom_range(99) < 25) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (busy);
		pixels_sent++;
	endtask

	task automatic stop_pixels();
		start <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom);
		endcase
	endfunction

	// mostly premultiplied pixels: colour bytes kept at or below the alpha byte
	function automatic pbm_pkg::pixel_in_t rand_pixel(logic [1:0] aslot);
		logic [7:0] t[4];
		logic [7:0] k[4];
		pbm_pkg::pixel_in_t p;
		bit premul;
		premul = ($urandom_range(99) < 70);
		for (int i = 0; i < 4; i++) begin
			t[i] = rand_byte();
			k[i] = rand_byte();
		end
		if (premul)
			for (int i = 0; i < 4; i++)
				if (i != aslot) begin
					t[i] = 8'($urandom_range(0, t[aslot]));
					k[i] = 8'($urandom_range(0, k[aslot]));
				end
		p = {t[0], t[1], t[2], t[3], k[0], k[1], k[2], k[3]};
		return p;
	endfunction

	initial begin
		pbm_pkg::pixel_in_t corner[8];
		logic [1:0] s[4];
		logic [3:0] m;
		blend_sb = new();
		no_gaps = 1'b0;
		pixels_sent = 0;
		phases_run = 0;
		arst_n = 1'b0;
		start = 1'b0;
		pixel = '0;
		cfg_valid = 1'b0;
		cfg_index = pbm_pkg::CFG_BLEND_MODE;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes under the reset settings
		corner = '{'0, '1,
			{32'h0000_0000, 32'hffff_ffff}, {32'hffff_ffff, 32'h0000_0000},
			{32'h8080_80ff, 32'h7f7f_7fff}, {32'hff00_0000, 32'h00ff_00ff},
			{32'h4020_10ff, 32'hc0e0_f080}, {32'hffff_ff40, 32'h1020_3080}};
		for (int i = 0; i < 8; i++) send_pixel(corner[i]);
		stop_pixels();

		// one pass per mode code, including the unused ones
		for (int mc = 0; mc < 16; mc++) begin
			drain();
			set_blend(4'(mc), 2'd0, 2'd1, 2'd2, 2'd3);
			send_pixel(corner[4 + (mc % 4)]);
			stop_pixels();
		end

		// shared slots and a slot no channel names
		drain();
		set_blend(pbm_pkg::MODE_OVERLAY, 2'd1, 2'd1, 2'd3, 2'd0);
		send_pixel(corner[6]);
		send_pixel(corner[5]);
		stop_pixels();

		// random phases; phase 3 runs with no gaps at all
		for (int ph = 0; ph < 14; ph++) begin
			drain();
			m = (ph < 12) ? 4'(ph) : 4'($urandom_range(12, 15));
			if (ph == 12) s = '{2'd3, 2'd3, 2'd3, 2'd3};
			else if (ph == 13) s = '{2'd0, 2'd0, 2'd0, 2'd0};
			else if (ph % 3 == 2)
				for (int i = 0; i < 4; i++) s[i] = 2'($urandom);
			else begin
				s = '{2'd0, 2'd1, 2'd2, 2'd3};
				s.shuffle();
			end
			set_blend(m, s[0], s[1], s[2], s[3]);
			no_gaps = (ph == 3);
			for (int n = 0; n < 128; n++) send_pixel(rand_pixel(s[3]));
			stop_pixels();
		end
		no_gaps = 1'b0;

		drain();
		$display("%0d pixel pairs over %0d register settings, %0d results checked",
			pixels_sent, phases_run, blend_sb.checked);
		if (blend_sb.errors == 0 && blend_sb.expected_pixels.size() == 0) begin
			$display("pixel_blend_modes_unit_tb OK");
		end else begin
			$display("pixel_blend_modes_unit_tb NOT OK");
		end
		$finish;
	end
endmodule
